/* rtl/mbe_pkg.sv */
package mbe_pkg;

	localparam int CoordW   = 32;
	localparam int IterW    = 16;
	localparam int CountW   = IterW + 1;
	localparam int InDataW  = 2 * CoordW;
	localparam int OutDataW = 40;

	localparam logic [IterW-1:0]  MAX_ITER_RST = 16'd500;
	localparam logic [CoordW-1:0] RADIUS_RST   = 32'h4000_0000;

	localparam logic REG_MAX_ITER = 1'b0;
	localparam logic REG_RADIUS   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

endpackage

/* rtl/mandelbrot_escape_test.sv */
// Escape-time test of one point c (Q4.28 real and imaginary parts) of the
// Mandelbrot set. Starting from z = 0 the block tests |z|^2 against
// escape_radius_sq and, while it stays below, applies z = z*z + c, at most
// max_iter + 1 times; it returns whether the final |z|^2 is below the radius
// and that |z|^2 saturated to 32 bits. Products are floored and saturated to
// the Q4.28 range. max_iter resets to 500. After a point is loaded, every
// iteration is a multiply step (ST_MUL) for re*re, im*im and re*im followed
// by an add, saturate and compare step (ST_EVAL). A finished result sits in
// an output register, so a new point is accepted while the previous result
// waits; the block stalls only if a second result completes before the first
// is taken. Registers: max_iter at 0x0, escape_radius_sq at 0x4; write them
// only while the block is idle.
module mandelbrot_escape_test import mbe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,  // [31:0] c_re, [63:32] c_im
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,  // [0] inside_res, [32:1] final_mag_sq
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [IterW-1:0]  max_iter_q;
	logic [CoordW-1:0] radius_q;
	logic              cfg_wr;
	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic              inside_res;
	logic [CoordW-1:0] final_mag_sq;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
			radius_q   <= RADIUS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAX_ITER: max_iter_q <= pwdata[IterW-1:0];
				REG_RADIUS:   radius_q   <= pwdata;
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_ITER: prdata = {16'd0, max_iter_q};
			REG_RADIUS:   prdata = radius_q;
			default:      prdata = '0;
		endcase
	end

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbe_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.max_iter         (max_iter_q),
		.escape_radius_sq (radius_q),
		.c_re             (s_axis_tdata[31:0]),
		.c_im             (s_axis_tdata[63:32]),
		.inside_res       (inside_res),
		.final_mag_sq     (final_mag_sq)
	);

	assign m_axis_tdata = {7'd0, final_mag_sq, inside_res};

endmodule

/* rtl/mbe_dp.sv */
module mbe_dp import mbe_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	input  logic [IterW-1:0]         max_iter,
	input  logic [CoordW-1:0]        escape_radius_sq,
	input  logic signed [CoordW-1:0] c_re,
	input  logic signed [CoordW-1:0] c_im,
	output logic                     inside_res,
	output logic [CoordW-1:0]        final_mag_sq
);

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v[35:31] == {5{v[35]}}) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = S32_MIN;
		end else begin
			r = S32_MAX;
		end
		return r;
	endfunction

	logic signed [31:0] c_re_q, c_im_q, z_re_q, z_im_q;
	logic [CountW-1:0]  k_q;
	logic signed [63:0] rr_s1, ii_s1, ri_s1;
	logic signed [63:0] rr_c, ii_c, ri_c;
	logic signed [31:0] rr_fx, ii_fx, ri_fx;
	logic signed [35:0] nr_sum, ni_sum;
	logic [63:0]        mag_sum;
	logic [31:0]        mag_c;
	logic [CountW-1:0]  total;
	logic               res_inside_q;
	logic [31:0]        res_mag_q;

	assign rr_c = z_re_q * z_re_q;
	assign ii_c = z_im_q * z_im_q;
	assign ri_c = z_re_q * z_im_q;

	// floor shift by 28 is the upper 36 bits of each product
	assign rr_fx = sat_s32(rr_s1[63:28]);
	assign ii_fx = sat_s32(ii_s1[63:28]);
	assign ri_fx = sat_s32(ri_s1[63:28]);

	assign nr_sum = {{4{rr_fx[31]}}, rr_fx} - {{4{ii_fx[31]}}, ii_fx}
		+ {{4{c_re_q[31]}}, c_re_q};
	assign ni_sum = {{3{ri_fx[31]}}, ri_fx, 1'b0} + {{4{c_im_q[31]}}, c_im_q};

	// both squares are non-negative and at most 2^62, so the sum fits 64 bits
	assign mag_sum = $unsigned(rr_s1) + $unsigned(ii_s1);
	assign mag_c   = (|mag_sum[63:60]) ? '1 : mag_sum[59:28];

	assign total    = {1'b0, max_iter} + CountW'(1);
	assign sts.done = (k_q == total) || (mag_c >= escape_radius_sq);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_re_q <= c_re;
			c_im_q <= c_im;
			z_re_q <= '0;
			z_im_q <= '0;
		end else if (cmd.step) begin
			z_re_q <= sat_s32(nr_sum);
			z_im_q <= sat_s32(ni_sum);
		end
		if (cmd.mul) begin
			rr_s1 <= rr_c;
			ii_s1 <= ii_c;
			ri_s1 <= ri_c;
		end
		if (cmd.emit) begin
			res_inside_q <= (mag_c < escape_radius_sq);
			res_mag_q    <= mag_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.load) begin
			k_q <= '0;
		end else if (cmd.step) begin
			k_q <= k_q + CountW'(1);
		end
	end

	assign inside_res   = res_inside_q;
	assign final_mag_sq = res_mag_q;

	a_step_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (k_q < total))
		else $error("update issued at or past the iteration limit");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.done)
		else $error("result captured before the escape test finished");

endmodule

/* rtl/mbe_ctrl.sv */
module mbe_ctrl import mbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_MUL;
			end
			ST_MUL: begin
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				if (!sts.done) state_nxt = ST_MUL;
				else if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_EVAL: begin
				// hold in place while a finished result still waits downstream
				cmd.step = !sts.done;
				cmd.emit = sts.done && out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.step, cmd.emit}))
		else $error("more than one datapath command at once");

	a_mul_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_EVAL))
		else $error("multiply stage not followed by evaluation");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("captured result not presented");

endmodule
